>>> design/chat_line_text_statistics_defines.svh
// Assertion macros shared by the chat line statistics RTL.
// Included by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef CHAT_LINE_TEXT_STATISTICS_DEFINES_SVH
`define CHAT_LINE_TEXT_STATISTICS_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication check
`define CSTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csts: same-cycle check failed");
// next-cycle implication check
`define CSTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csts: next-cycle check failed");
`else
`define CSTS_ASSERT_IMPL(label, ante, cons)
`define CSTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/csts_pkg.sv
// Shared types and constants for the chat line text statistics block.
// No dependencies; imported by every module of the block.
package csts_pkg;

  // pattern register layout
  localparam int CFG_W     = 53;
  localparam int REG_COUNT = 8;
  localparam int IDX_W     = 3;
  localparam int LEN_LSB   = 48;
  localparam int CLS_LSB   = 51;

  // pattern classes
  localparam logic [1:0] CLS_HAPPY  = 2'd0;
  localparam logic [1:0] CLS_SAD    = 2'd1;
  localparam logic [1:0] CLS_OTHER  = 2'd2;
  localparam logic [1:0] CLS_UNUSED = 2'd3;
  localparam int CLASS_COUNT = 3;

  // action prefix: 0x01 "ACTION ", byte i at bits 8i+7:8i
  localparam int PREFIX_LEN = 8;
  localparam logic [63:0] ACTION_PREFIX = 64'h204E_4F49_5443_4101;
  localparam logic [7:0] CTRL_A = 8'h01;

  // saturation limits
  localparam logic [9:0]  LETTER_MAX = 10'h3FF;
  localparam logic [8:0]  WORD_MAX   = 9'h1FF;
  localparam logic [11:0] HIT_MAX    = 12'hFFF;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       raw_en;
    logic       strip_en;
    logic       last;
    logic       action;
  } op_t;

  // counters of one counting track
  typedef struct packed {
    logic [9:0]                    letters;
    logic [8:0]                    words;
    logic [CLASS_COUNT-1:0][11:0]  hits;
  } counts_t;

endpackage

>>> design/csts_front.sv
// Front end: accepts line bytes, tracks position and action prefix, classifies
// each byte for the raw and stripped tracks. Depends on csts_pkg.
module csts_front #(
  parameter int MAX_LINE_BYTES = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     msg_byte,
  input  logic           is_last,
  input  logic           q_full,
  output logic           in_stall,
  output logic           push,
  output csts_pkg::op_t  op
);
  import csts_pkg::*;

  localparam int PW = $clog2(MAX_LINE_BYTES + 1);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic          prefix_ok;
  logic          prefix_ok_next;
  logic          kept;
  logic          final_kept;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify the byte against position and prefix
  always_comb begin
    kept           = pos < PW'(MAX_LINE_BYTES);
    final_kept     = is_last || (pos == PW'(MAX_LINE_BYTES - 1));
    pos_next       = pos;
    prefix_ok_next = prefix_ok;
    if (kept) begin
      pos_next = pos + 1'b1;
      if (pos < PW'(PREFIX_LEN) &&
          msg_byte != ACTION_PREFIX[8*int'(pos[2:0]) +: 8]) begin
        prefix_ok_next = 1'b0;
      end
    end
    op.data     = msg_byte;
    op.raw_en   = kept;
    // a trailing 0x01 on the last kept byte never enters the stripped track
    op.strip_en = kept && (pos >= PW'(PREFIX_LEN)) &&
                  !(msg_byte == CTRL_A && final_kept);
    op.last     = is_last;
    op.action   = prefix_ok_next && (pos_next >= PW'(PREFIX_LEN));
  end

  // line position state, cleared at end of line
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      prefix_ok <= 1'b1;
    end else if (push) begin
      if (is_last) begin
        pos       <= '0;
        prefix_ok <= 1'b1;
      end else begin
        pos       <= pos_next;
        prefix_ok <= prefix_ok_next;
      end
    end
  end

endmodule

>>> design/csts_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on csts_pkg and the assertion macro header.
`include "chat_line_text_statistics_defines.svh"
module csts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csts_pkg::op_t  wr_op,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output csts_pkg::op_t  rd_op
);
  import csts_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign rd_op     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CSTS_ASSERT_IMPL(a_no_overflow, push, count != CW'(DEPTH))
  `CSTS_ASSERT_IMPL(a_no_underflow, pop, count != '0)
  `CSTS_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(DEPTH))

endmodule

>>> design/csts_track.sv
// One counting track: byte history, word state, saturating counters and
// parallel pattern compare. Depends on csts_pkg.
module csts_track #(
  parameter int MAX_PATTERN_BYTES = 6,
  parameter int PATTERN_SLOTS     = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          feed,
  input  logic                                          clear,
  input  logic [7:0]                                    data,
  input  logic [PATTERN_SLOTS-1:0][csts_pkg::CFG_W-1:0] pattern,
  output csts_pkg::counts_t                             counts_next
);
  import csts_pkg::*;

  localparam int HW  = 8 * MAX_PATTERN_BYTES;
  localparam int HVW = $clog2(MAX_PATTERN_BYTES + 1);

  logic [HW-1:0]            history;
  logic [HW-1:0]            hist_n;
  logic [HVW-1:0]           hist_valid;
  logic [HVW-1:0]           hv_n;
  logic                     in_word;
  logic                     in_word_n;
  counts_t                  counts;
  logic [PATTERN_SLOTS-1:0] slot_match;
  logic                     space;
  logic [3:0]               class_n [CLASS_COUNT];
  logic [12:0]              hit_sum [CLASS_COUNT];

  // does the pattern end at the newest history byte
  function automatic logic slot_hit(input logic [HW-1:0] hist,
                                    input logic [CFG_W-1:0] pat,
                                    input logic [HVW-1:0] hv);
    logic [2:0] len;
    logic [1:0] cls;
    logic       ok;
    logic [2:0] idx;
    logic [7:0] hb;
    len = pat[LEN_LSB +: 3];
    cls = pat[CLS_LSB +: 2];
    ok  = (len != 3'd0) && (len <= 3'(MAX_PATTERN_BYTES)) &&
          (cls != CLS_UNUSED) && (int'(len) <= int'(hv));
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (i < int'(len)) begin
        idx = 3'(int'(len) - 1 - i);
        hb  = 8'h00;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
          if (int'(idx) == j) begin
            hb = hist[8*j +: 8];
          end
        end
        if (hb != pat[8*i +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // next state of the track for one fed byte
  always_comb begin
    space       = (data inside {[8'd9:8'd13], 8'd32});
    hist_n      = history;
    hv_n        = hist_valid;
    in_word_n   = in_word;
    counts_next = counts;
    slot_match  = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      class_n[c] = 4'd0;
      hit_sum[c] = 13'd0;
    end
    if (feed) begin
      hist_n = (history << 8) | HW'(data);
      if (hist_valid != HVW'(MAX_PATTERN_BYTES)) begin
        hv_n = hist_valid + 1'b1;
      end
      if (counts.letters != LETTER_MAX) begin
        counts_next.letters = counts.letters + 1'b1;
      end
      if (space) begin
        in_word_n = 1'b0;
      end else if (!in_word) begin
        in_word_n = 1'b1;
        if (counts.words != WORD_MAX) begin
          counts_next.words = counts.words + 1'b1;
        end
      end
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        slot_match[s] = slot_hit(hist_n, pattern[s], hv_n);
      end
      for (int c = 0; c < CLASS_COUNT; c++) begin
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
          if (slot_match[s] && pattern[s][CLS_LSB +: 2] == 2'(c)) begin
            class_n[c] = class_n[c] + 1'b1;
          end
        end
        hit_sum[c] = {1'b0, counts.hits[c]} + 13'(class_n[c]);
        counts_next.hits[c] = (hit_sum[c] > 13'(HIT_MAX)) ? HIT_MAX : hit_sum[c][11:0];
      end
    end
  end

  // track registers, cleared after each line
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      history    <= '0;
      hist_valid <= '0;
      in_word    <= 1'b0;
      counts     <= '0;
    end else if (feed) begin
      history    <= hist_n;
      hist_valid <= hv_n;
      in_word    <= in_word_n;
      counts     <= counts_next;
    end
  end

endmodule

>>> design/csts_back.sv
// Back end: runs the raw and stripped tracks, latches the chosen counters at
// end of line and forms the result register. Depends on csts_pkg, csts_track.
`include "chat_line_text_statistics_defines.svh"
module csts_back #(
  parameter int MAX_PATTERN_BYTES = 6,
  parameter int PATTERN_SLOTS     = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_valid,
  input  csts_pkg::op_t                                 q_op,
  output logic                                          q_pop,
  input  logic [PATTERN_SLOTS-1:0][csts_pkg::CFG_W-1:0] pattern,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [9:0]                                    letter_count,
  output logic [8:0]                                    word_count,
  output logic                                          action_flag,
  output logic [11:0]                                   happy_hits,
  output logic [11:0]                                   sad_hits,
  output logic [11:0]                                   other_hits
);
  import csts_pkg::*;

  counts_t     raw_next;
  counts_t     strip_next;
  counts_t     res_counts;
  logic        res_valid;
  logic        res_action;
  logic        res_free;
  logic        out_load;
  logic        pop;
  logic [13:0] total;
  logic [8:0]  words_left;

  assign out_load = res_valid && (!out_valid || !out_stall);
  assign res_free = !res_valid || out_load;
  assign pop      = q_valid && res_free;
  assign q_pop    = pop;

  csts_track #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .PATTERN_SLOTS    (PATTERN_SLOTS)
  ) u_raw (
    .clk        (clk),
    .rst        (rst),
    .feed       (pop && q_op.raw_en),
    .clear      (pop && q_op.last),
    .data       (q_op.data),
    .pattern    (pattern),
    .counts_next(raw_next)
  );

  csts_track #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .PATTERN_SLOTS    (PATTERN_SLOTS)
  ) u_strip (
    .clk        (clk),
    .rst        (rst),
    .feed       (pop && q_op.strip_en),
    .clear      (pop && q_op.last),
    .data       (q_op.data),
    .pattern    (pattern),
    .counts_next(strip_next)
  );

  // end-of-line capture of the selected track
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && q_op.last) begin
      res_valid <= 1'b1;
    end else if (out_load) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_op.last) begin
      res_counts <= q_op.action ? strip_next : raw_next;
      res_action <= q_op.action;
    end
  end

  // words minus all hits, floored at zero
  always_comb begin
    total = 14'(res_counts.hits[CLS_HAPPY]) + 14'(res_counts.hits[CLS_SAD]) +
            14'(res_counts.hits[CLS_OTHER]);
    if (14'(res_counts.words) > total) begin
      words_left = 9'(14'(res_counts.words) - total);
    end else begin
      words_left = 9'd0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      letter_count <= res_counts.letters;
      word_count   <= words_left;
      action_flag  <= res_action;
      happy_hits   <= res_counts.hits[CLS_HAPPY];
      sad_hits     <= res_counts.hits[CLS_SAD];
      other_hits   <= res_counts.hits[CLS_OTHER];
    end
  end

  `CSTS_ASSERT_IMPL(a_no_result_overwrite, pop && q_op.last, !res_valid || out_load)
  `CSTS_ASSERT_NEXT(a_last_loads_result, pop && q_op.last, res_valid)

endmodule

>>> design/chat_line_text_statistics.sv
// Chat line text statistics, top level: pattern registers, front, queue, back.
// Depends on csts_pkg, csts_front, csts_queue, csts_back.
//
// Usage: the bytes of a line enter one per item on the input channel
// (in_valid/in_stall, msg_byte, is_last). The item with is_last high ends the
// line and causes exactly one result item on the output channel
// (out_valid/out_stall): letter, word and pattern-hit counts plus action flag.
// Other bytes cause no result. Bytes past MAX_LINE_BYTES are dropped except
// that is_last still closes the line.
// Throughput: one byte per cycle, sustained while the output is not stalled; the two
// tracks and all pattern compares finish within the back stage for each byte.
// The last byte of a line goes from the four-entry queue into the capture stage
// and then into the result register, where out_valid rises.
// A stalled result holds in the output register and one more result may wait
// in the capture stage; the back then stops taking bytes, the queue fills and
// in_stall rises.
// Reset clears all line state and the pattern registers (all slots unused).
// Pattern registers are written through wr_en/wr_index/wr_data; the user must
// write them only while idle, which the block itself does not enforce.
module chat_line_text_statistics #(
  parameter int MAX_LINE_BYTES    = 512,
  parameter int MAX_PATTERN_BYTES = 6,
  parameter int PATTERN_SLOTS     = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [csts_pkg::IDX_W-1:0]   wr_index,
  input  logic [csts_pkg::CFG_W-1:0]   wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   msg_byte,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [9:0]                   letter_count,
  output logic [8:0]                   word_count,
  output logic                         action_flag,
  output logic [11:0]                  happy_hits,
  output logic [11:0]                  sad_hits,
  output logic [11:0]                  other_hits
);
  import csts_pkg::*;

  logic [PATTERN_SLOTS-1:0][CFG_W-1:0] pattern;
  logic                                push;
  logic                                q_full;
  logic                                q_valid;
  logic                                q_pop;
  op_t                                 wr_op;
  op_t                                 q_op;

  // pattern registers; slots beyond PATTERN_SLOTS are not stored
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
    end else if (wr_en) begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        if (wr_index == IDX_W'(s)) begin
          pattern[s] <= wr_data;
        end
      end
    end
  end

  csts_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .msg_byte(msg_byte),
    .is_last (is_last),
    .q_full  (q_full),
    .in_stall(in_stall),
    .push    (push),
    .op      (wr_op)
  );

  csts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_op    (wr_op),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .rd_op    (q_op)
  );

  csts_back #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .PATTERN_SLOTS    (PATTERN_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .q_pop       (q_pop),
    .pattern     (pattern),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .letter_count(letter_count),
    .word_count  (word_count),
    .action_flag (action_flag),
    .happy_hits  (happy_hits),
    .sad_hits    (sad_hits),
    .other_hits  (other_hits)
  );

endmodule

>>> tb/tb_chat_line_text_statistics.sv
// Self-checking testbench for chat_line_text_statistics: chat lines go in byte by byte
// and every line result is checked against a line-statistics predictor kept in the bench.
// Depends on csts_pkg and the chat_line_text_statistics RTL.
module tb_chat_line_text_statistics;
  import csts_pkg::*;

  localparam int MAX_LINE_BYTES    = 512;
  localparam int MAX_PATTERN_BYTES = 6;
  localparam int PATTERN_SLOTS     = 8;
  localparam int QUIET_LIMIT       = 2000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES      = 8;     // extra idle wait once every expected result is checked
  localparam int LONG_HOLD         = 120;   // receiver hold-off that backs up the queue
  localparam int RAW               = 0;     // whole-line track
  localparam int STRIP             = 1;     // text after the action prefix

  // bytes used to build text and patterns so that hits are frequent
  localparam logic [7:0] TEXT_POOL [10] = '{
    8'h61, 8'h6C, 8'h6F, 8'h3A, 8'h29,      // a l o : )
    8'h28, 8'h20, 8'h01, 8'h09, 8'h62       // ( space ctrl-A tab b
  };
  // whitespace and its neighbors (8, 14, 31, 33 are not whitespace)
  localparam logic [7:0] SPACE_MIX [16] = '{
    8'h08, 8'h09, 8'h78, 8'h0A, 8'h0B, 8'h79, 8'h79, 8'h0C,
    8'h0D, 8'h0E, 8'h20, 8'h20, 8'h7A, 8'h1F, 8'h21, 8'h0D
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [9:0]  letters;
    logic [8:0]  words;
    logic        action;
    logic [11:0] happy;
    logic [11:0] sad;
    logic [11:0] other;
  } line_stats_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       msg_byte = 8'h00;
  logic             is_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [9:0]       letter_count;
  logic [8:0]       word_count;
  logic             action_flag;
  logic [11:0]      happy_hits;
  logic [11:0]      sad_hits;
  logic [11:0]      other_hits;

  chat_line_text_statistics #(
    .MAX_LINE_BYTES   (MAX_LINE_BYTES),
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .PATTERN_SLOTS    (PATTERN_SLOTS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .msg_byte    (msg_byte),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .letter_count(letter_count),
    .word_count  (word_count),
    .action_flag (action_flag),
    .happy_hits  (happy_hits),
    .sad_hits    (sad_hits),
    .other_hits  (other_hits)
  );

  always #1 clk = ~clk;

  // stimulus and expectation stores
  byte_item_t  pending_bytes [$];
  line_stats_t stats_due [$];
  logic [7:0]  line_buf [$];
  int          items_queued = 0;
  int          error_count = 0;

  // pacing controls, changed only at the falling edge
  int src_mode = 1;
  int snk_mode = 1;
  int hold_req = 0;

  // predictor state
  logic [CFG_W-1:0] pattern_shadow [REG_COUNT];
  logic [CFG_W-1:0] cfg_plan [REG_COUNT];
  logic [47:0]      trk_hist [2];
  int               trk_fill [2];
  bit               trk_in_word [2];
  int               trk_letters [2];
  int               trk_words [2];
  int               trk_hits [2][CLASS_COUNT];
  int               line_pos;
  bit               prefix_ok;
  bit               held_valid;
  logic [7:0]       held_byte;

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void clear_line_state();
    line_pos   = 0;
    prefix_ok  = 1'b1;
    held_valid = 1'b0;
    held_byte  = 8'h00;
    for (int t = 0; t < 2; t++) begin
      trk_hist[t]    = '0;
      trk_fill[t]    = 0;
      trk_in_word[t] = 1'b0;
      trk_letters[t] = 0;
      trk_words[t]   = 0;
      for (int c = 0; c < CLASS_COUNT; c++) trk_hits[t][c] = 0;
    end
  endfunction

  // push one byte into a counting track and score every pattern slot
  function automatic void feed_track(input int tk, input logic [7:0] b);
    logic [2:0] len;
    logic [1:0] cls;
    bit         hit;
    trk_hist[tk] = {trk_hist[tk][39:0], b};
    if (trk_fill[tk] < MAX_PATTERN_BYTES) trk_fill[tk]++;
    if (trk_letters[tk] < LETTER_MAX) trk_letters[tk]++;
    if ((b >= 8'd9 && b <= 8'd13) || b == 8'd32) begin
      trk_in_word[tk] = 1'b0;
    end else if (!trk_in_word[tk]) begin
      trk_in_word[tk] = 1'b1;
      if (trk_words[tk] < WORD_MAX) trk_words[tk]++;
    end
    for (int s = 0; s < PATTERN_SLOTS && s < REG_COUNT; s++) begin
      len = pattern_shadow[s][LEN_LSB +: 3];
      cls = pattern_shadow[s][CLS_LSB +: 2];
      if (len != 0 && len <= MAX_PATTERN_BYTES && cls != CLS_UNUSED && len <= trk_fill[tk]) begin
        hit = 1'b1;
        // newest byte of the history lines up with the last pattern byte
        for (int i = 0; i < len; i++) begin
          if (pattern_shadow[s][8*i +: 8] != trk_hist[tk][8*(len-1-i) +: 8]) hit = 1'b0;
        end
        if (hit && trk_hits[tk][cls] < HIT_MAX) trk_hits[tk][cls]++;
      end
    end
  endfunction

  // one accepted byte; returns 1 with the line statistics on the last byte
  function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                      output line_stats_t res);
    int tk;
    int total;
    int words;
    bit is_action;
    res = '0;
    if (line_pos < MAX_LINE_BYTES) begin
      if (line_pos < PREFIX_LEN && b != ACTION_PREFIX[8*line_pos +: 8]) prefix_ok = 1'b0;
      feed_track(RAW, b);
      // stripped track runs one byte late so a trailing ctrl-A can be dropped
      if (line_pos >= PREFIX_LEN) begin
        if (held_valid) feed_track(STRIP, held_byte);
        held_byte  = b;
        held_valid = 1'b1;
      end
      line_pos++;
    end
    if (!last) return 1'b0;
    is_action = prefix_ok && line_pos >= PREFIX_LEN;
    tk = RAW;
    if (is_action) begin
      if (held_valid && held_byte != CTRL_A) feed_track(STRIP, held_byte);
      tk = STRIP;
    end
    total = trk_hits[tk][CLS_HAPPY] + trk_hits[tk][CLS_SAD] + trk_hits[tk][CLS_OTHER];
    words = (trk_words[tk] > total) ? trk_words[tk] - total : 0;
    res.letters = trk_letters[tk][9:0];
    res.words   = words[8:0];
    res.action  = is_action;
    res.happy   = trk_hits[tk][CLS_HAPPY][11:0];
    res.sad     = trk_hits[tk][CLS_SAD][11:0];
    res.other   = trk_hits[tk][CLS_OTHER][11:0];
    clear_line_state();
    return 1'b1;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return TEXT_POOL[r % 10];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] make_pattern(input string s, input logic [1:0] cls);
    logic [CFG_W-1:0] v;
    v = '0;
    for (int i = 0; i < s.len(); i++) v[8*i +: 8] = s[i];
    v[LEN_LSB +: 3] = 3'(s.len());
    v[CLS_LSB +: 2] = cls;
    return v;
  endfunction

  // random slot: mostly short lengths over the text pool, sometimes any value at all
  function automatic logic [CFG_W-1:0] rand_pattern(input bit wild);
    logic [CFG_W-1:0] v;
    int r;
    if (wild) return CFG_W'({$urandom(), $urandom()});
    v = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) v[8*i +: 8] = pick_text_byte();
    r = $urandom_range(0, 9);
    if (r == 0) v[LEN_LSB +: 3] = 3'd0;
    else if (r < 8) v[LEN_LSB +: 3] = 3'(1 + r % 3);
    else if (r == 8) v[LEN_LSB +: 3] = 3'($urandom_range(4, 6));
    else v[LEN_LSB +: 3] = 3'd7;
    v[CLS_LSB +: 2] = ($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, 2)) : CLS_UNUSED;
    return v;
  endfunction

  // line building
  task automatic buf_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  task automatic buf_text(input string s);
    for (int i = 0; i < s.len(); i++) buf_byte(s[i]);
  endtask

  task automatic buf_repeat(input logic [7:0] b, input int n);
    repeat (n) buf_byte(b);
  endtask

  task automatic buf_prefix(input int n);
    for (int i = 0; i < n; i++) buf_byte(ACTION_PREFIX[8*i +: 8]);
  endtask

  task automatic send_line();
    byte_item_t it;
    for (int i = 0; i < line_buf.size(); i++) begin
      it.data = line_buf[i];
      it.last = (i == line_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), it);
    end
    items_queued += line_buf.size();
    line_buf.delete();
  endtask

  // mostly well-formed plain and action lines, some broken prefixes and raw noise
  task automatic queue_random_line(input int max_len);
    int kind;
    int len;
    int cut;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(0, max_len);
    if (kind < 35) begin
      buf_prefix(PREFIX_LEN);
      repeat (len) buf_byte(pick_text_byte());
      if ($urandom_range(0, 1)) buf_byte(CTRL_A);
    end else if (kind < 50) begin
      cut = $urandom_range(0, PREFIX_LEN - 1);
      buf_prefix(cut);
      buf_byte(8'($urandom_range(0, 255)));
      repeat (len) buf_byte(pick_text_byte());
    end else if (kind < 60) begin
      repeat (len + 1) buf_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat (len + 1) buf_byte(pick_text_byte());
    end
    send_line();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || stats_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all eight slots from cfg_plan; only called while idle
  task automatic program_patterns();
    for (int s = 0; s < REG_COUNT; s++) begin
      @(posedge clk);
      wr_en    <= 1'b1;
      wr_index <= IDX_W'(s);
      wr_data  <= cfg_plan[s];
      pattern_shadow[s] = cfg_plan[s];
    end
    @(posedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [11:0] got, input logic [11:0] want);
    if (got !== want) log_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // input driver: presents queued bytes, predicts each accepted one
  byte_item_t  drv_item;
  line_stats_t drv_stats;
  int          src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_byte(msg_byte, is_last, drv_stats)) begin
          stats_due.insert(stats_due.size(), drv_stats);
        end
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          drv_item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          msg_byte <= drv_item.data;
          is_last  <= drv_item.last;
          src_gap = pick_gap(src_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver pacing
  line_stats_t mon_stats;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          sink_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      sink_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          log_error("result item with no line pending");
        end else begin
          mon_stats = stats_due.pop_front();
          check_field("letter_count", 12'(letter_count), 12'(mon_stats.letters));
          check_field("word_count", 12'(word_count), 12'(mon_stats.words));
          check_field("action_flag", 12'(action_flag), 12'(mon_stats.action));
          check_field("happy_hits", happy_hits, mon_stats.happy);
          check_field("sad_hits", sad_hits, mon_stats.sad);
          check_field("other_hits", other_hits, mon_stats.other);
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sink_left > 0) begin
        sink_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        sink_left = pick_gap(snk_mode);
      end
    end
  end

  // watchdog: too long without any transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    int goal;
    clear_line_state();
    for (int s = 0; s < REG_COUNT; s++) pattern_shadow[s] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset patterns (all slots unused): framing, whitespace, action detection
    buf_text("a");
    send_line();
    buf_byte(8'h00);
    send_line();
    buf_byte(8'hFF);
    send_line();
    foreach (SPACE_MIX[i]) buf_byte(SPACE_MIX[i]);
    send_line();
    buf_prefix(PREFIX_LEN - 1);        // too short to be an action
    send_line();
    buf_prefix(PREFIX_LEN);            // bare prefix: empty action text
    send_line();
    buf_prefix(PREFIX_LEN);            // prefix plus trailer only: empty text
    buf_byte(CTRL_A);
    send_line();
    buf_prefix(PREFIX_LEN);
    buf_text("waves hello");
    buf_byte(CTRL_A);
    send_line();
    buf_prefix(PREFIX_LEN);
    buf_text("waves");
    send_line();
    buf_prefix(6);                     // broken prefix
    buf_text("X hi");
    send_line();
    buf_prefix(PREFIX_LEN);            // ctrl-A not at the end is counted
    buf_byte(CTRL_A);
    buf_text("x");
    send_line();
    wait_idle();

    // overlaps, duplicates, short history, unused by class and by length
    cfg_plan[0] = make_pattern(":)", CLS_HAPPY);
    cfg_plan[1] = make_pattern(":(", CLS_SAD);
    cfg_plan[2] = make_pattern("lol", CLS_OTHER);
    cfg_plan[3] = make_pattern("aa", CLS_HAPPY);
    cfg_plan[4] = make_pattern("abcdef", CLS_SAD);
    cfg_plan[5] = make_pattern(":)", CLS_HAPPY);
    cfg_plan[6] = make_pattern("a", CLS_UNUSED);
    cfg_plan[7] = make_pattern("aaaaaa", CLS_OTHER);
    cfg_plan[7][LEN_LSB +: 3] = 3'd7;
    program_patterns();
    buf_text("aaaa :) lolol :(");
    send_line();
    buf_text("abcdef abcdef");
    send_line();
    buf_text("a");
    send_line();
    buf_text(":) :) :)");
    send_line();
    buf_prefix(PREFIX_LEN);
    buf_text(":) aaa");
    buf_byte(CTRL_A);
    send_line();
    buf_prefix(PREFIX_LEN);
    buf_text("lolol");
    send_line();
    wait_idle();

    // hit saturation on a long line: every slot hits on each kept 'a'
    for (int s = 0; s < REG_COUNT; s++) cfg_plan[s] = make_pattern("a", CLS_HAPPY);
    program_patterns();
    buf_repeat(8'h61, MAX_LINE_BYTES + 1);   // the dropped byte carries is_last
    send_line();
    wait_idle();

    // all-ones slots: length and class both out of range
    for (int s = 0; s < REG_COUNT; s++) cfg_plan[s] = '1;
    program_patterns();
    repeat (4) queue_random_line(12);
    wait_idle();

    // random settings with varied pacing, one phase with arbitrary register values
    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < REG_COUNT; s++) begin
        cfg_plan[s] = rand_pattern(ph == 1 && $urandom_range(0, 1) == 1);
      end
      program_patterns();
      src_mode = (ph != 1);
      snk_mode = (ph != 2);
      goal = items_queued + 40;
      while (items_queued < goal) queue_random_line(16);
      wait_idle();
    end

    // back-pressure: sender streams while the receiver holds off
    src_mode = 0;
    snk_mode = 0;
    repeat (4) queue_random_line(24);
    buf_repeat(8'h20, 2);
    repeat (24) buf_byte(pick_text_byte());
    send_line();
    hold_req++;
    wait_idle();

    // closing random phase
    for (int s = 0; s < REG_COUNT; s++) cfg_plan[s] = rand_pattern(1'b0);
    program_patterns();
    src_mode = 1;
    snk_mode = 1;
    goal = items_queued + 30;
    while (items_queued < goal) queue_random_line(16);
    wait_idle();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
